// ----- sv/mrrg_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrg_pkg
// Shared types and codes for the round-robin multi-queue gather block.
// ----------------------------------------------------------------------------
package mrrg_pkg;

  // request modes on the request port
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_GATHER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE   = 2'd0;
  localparam logic [1:0] CFG_GROUP    = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_GATHER = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  queue;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic [63:0] key_out;
    logic [3:0]  source;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  queue;
    logic [63:0] key;
  } cmd_t;

  typedef struct packed {
    logic [4:0] active_queues;
    logic [3:0] group_size;
    logic [7:0] capacity;
  } cfg_t;

endpackage

// ----- sv/mrrg_front.sv -----
// ----------------------------------------------------------------------------
// mrrg_front
// Takes request words, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module mrrg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mrrg_pkg::req_t req_i,
  output mrrg_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);

  mrrg_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           keep;
  mrrg_pkg::op_e  op;
  logic           enq;
  logic           deq;

  always_comb begin
    keep = 1'b1;
    op   = mrrg_pkg::OP_PUSH;
    case (req_i.mode)
      mrrg_pkg::MODE_PUSH:   op = mrrg_pkg::OP_PUSH;
      mrrg_pkg::MODE_POP:    op = mrrg_pkg::OP_POP;
      mrrg_pkg::MODE_GATHER: op = mrrg_pkg::OP_GATHER;
      default:               keep = 1'b0;
    endcase
  end

  assign busy        = (cnt_q == 2'd2);
  assign enq         = start && !busy && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_ptr_q].op    <= op;
      fifo_q[wr_ptr_q].queue <= req_i.queue;
      fifo_q[wr_ptr_q].key   <= req_i.key;
    end
  end

endmodule

// ----- sv/mrrg_back.sv -----
// ----------------------------------------------------------------------------
// mrrg_back
// Executes push, pop and gather against the key stacks and fill counts.
// ----------------------------------------------------------------------------
module mrrg_back #(
  parameter int MAX_QUEUES = 16,
  parameter int DEPTH      = 128,
  parameter int KEY_BITS   = 64,
  parameter int MAX_GROUP  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrrg_pkg::cfg_t cfg_i,
  input  mrrg_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output mrrg_pkg::res_t res_o,
  output logic           res_strobe_o
);

  localparam int QW      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int AW      = $clog2(MAX_QUEUES + 1);
  localparam int FW      = $clog2(DEPTH + 1);
  localparam int GW      = $clog2(MAX_GROUP + 1);
  localparam int PW      = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int ENTRIES = MAX_QUEUES * DEPTH;
  localparam int MW      = $clog2(ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_REDUCE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_POP    = 6'b010000,
    S_WAIT   = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  mrrg_pkg::cmd_t        cur_q;
  logic [FW-1:0]         fill_q [MAX_QUEUES];
  logic [QW-1:0]         sp_q, sp_d;
  logic [QW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         i_q, i_d;
  logic [GW-1:0]         cnt_q, cnt_d;
  logic [PW-1:0]         k_q, k_d;
  logic [QW-1:0]         pick_q [MAX_GROUP];
  logic                  rd_valid_q;
  logic [QW-1:0]         rd_src_q;
  logic                  rd_last_q, rd_last_d;
  logic [KEY_BITS-1:0]   rdata_q;
  logic [KEY_BITS-1:0]   mem [ENTRIES];
  mrrg_pkg::res_t        res_q;
  logic                  strobe_q;

  logic [AW-1:0]         act;
  logic [GW-1:0]         grp;
  logic [FW-1:0]         cap;
  logic [QW-1:0]         q_idx;
  logic                  q_act;
  logic [QW-1:0]         rd_idx;
  logic [FW-1:0]         fill_rd, fill_wd;
  logic                  fill_we;
  logic [MW-1:0]         addr_base, mem_waddr, mem_raddr;
  logic                  mem_we, mem_re;
  logic                  emit_v;
  mrrg_pkg::status_e     emit_st;
  logic [3:0]            emit_src;
  logic                  pick_we;
  logic                  take;
  logic                  hit;
  logic [GW-1:0]         cnt_hit;
  logic [AW-1:0]         sp_inc, idx_inc;
  logic [QW-1:0]         sp_wrap, idx_wrap;

  always_comb begin
    if (cfg_i.active_queues == '0) act = AW'(1);
    else if (cfg_i.active_queues > MAX_QUEUES) act = AW'(MAX_QUEUES);
    else act = AW'(cfg_i.active_queues);
    if (cfg_i.group_size == '0) grp = GW'(1);
    else if (cfg_i.group_size > MAX_GROUP) grp = GW'(MAX_GROUP);
    else grp = GW'(cfg_i.group_size);
    if (cfg_i.capacity > DEPTH) cap = FW'(DEPTH);
    else cap = FW'(cfg_i.capacity);
  end

  assign q_idx    = QW'(cur_q.queue);
  assign q_act    = (cur_q.queue < act);
  assign sp_inc   = AW'(sp_q) + AW'(1);
  assign sp_wrap  = (sp_inc == act) ? '0 : QW'(sp_inc);
  assign idx_inc  = AW'(idx_q) + AW'(1);
  assign idx_wrap = (idx_inc == act) ? '0 : QW'(idx_inc);

  always_comb begin
    case (state_q)
      S_SCAN:  rd_idx = idx_q;
      S_POP:   rd_idx = pick_q[k_q];
      default: rd_idx = q_idx;
    endcase
  end

  assign fill_rd   = fill_q[rd_idx];
  assign hit       = (fill_rd != '0);
  assign cnt_hit   = cnt_q + GW'(hit);
  assign addr_base = MW'(rd_idx) * MW'(DEPTH);
  assign mem_waddr = addr_base + MW'(fill_rd);
  assign mem_raddr = addr_base + MW'(fill_rd - 1'b1);
  assign take      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    idx_d       = idx_q;
    i_d         = i_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    fill_we     = 1'b0;
    fill_wd     = fill_rd;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    emit_v      = 1'b0;
    emit_st     = mrrg_pkg::ST_OK;
    emit_src    = cur_q.queue;
    pick_we     = 1'b0;
    cmd_ready_o = 1'b0;
    rd_last_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.op == mrrg_pkg::OP_GATHER) state_d = S_REDUCE;
          else state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (cur_q.op == mrrg_pkg::OP_PUSH) begin
          emit_v = 1'b1;
          if (!q_act) begin
            emit_st = mrrg_pkg::ST_FULL;
          end else if (fill_rd >= cap) begin
            emit_st = mrrg_pkg::ST_FULL;
          end else begin
            mem_we  = 1'b1;
            fill_we = 1'b1;
            fill_wd = fill_rd + 1'b1;
          end
        end else begin
          if (!q_act) begin
            emit_v  = 1'b1;
            emit_st = mrrg_pkg::ST_EMPTY;
          end else if (fill_rd == '0) begin
            emit_v  = 1'b1;
            emit_st = mrrg_pkg::ST_EMPTY;
          end else begin
            fill_we   = 1'b1;
            fill_wd   = fill_rd - 1'b1;
            mem_re    = 1'b1;
            rd_last_d = 1'b1;
            state_d   = S_WAIT;
          end
        end
      end
      S_REDUCE: begin
        // bring a stale start pointer below the active count
        if (sp_q >= act) begin
          sp_d = QW'(sp_q - act);
        end else begin
          idx_d   = sp_q;
          i_d     = '0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          pick_we = 1'b1;
          cnt_d   = cnt_hit;
        end
        if (cnt_hit == grp) begin
          sp_d    = sp_wrap;
          k_d     = '0;
          state_d = S_POP;
        end else if (i_q + 1'b1 == act) begin
          sp_d     = sp_wrap;
          emit_v   = 1'b1;
          emit_st  = mrrg_pkg::ST_NOT_READY;
          emit_src = 4'(sp_q);
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_wrap;
          i_d   = i_q + 1'b1;
        end
      end
      S_POP: begin
        fill_we   = 1'b1;
        fill_wd   = fill_rd - 1'b1;
        mem_re    = 1'b1;
        rd_last_d = (GW'(k_q) + 1'b1 == cnt_q);
        if (rd_last_d) state_d = S_WAIT;
        else k_d = k_q + 1'b1;
      end
      S_WAIT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sp_q       <= '0;
      idx_q      <= '0;
      i_q        <= '0;
      cnt_q      <= '0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
      strobe_q   <= 1'b0;
      for (int n = 0; n < MAX_QUEUES; n++) fill_q[n] <= '0;
    end else begin
      state_q    <= state_d;
      sp_q       <= sp_d;
      idx_q      <= idx_d;
      i_q        <= i_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      rd_valid_q <= mem_re;
      strobe_q   <= emit_v || rd_valid_q;
      if (fill_we) fill_q[rd_idx] <= fill_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= cmd_i;
    if (pick_we) pick_q[cnt_q[PW-1:0]] <= idx_q;
    if (mem_re) begin
      rd_src_q  <= rd_idx;
      rd_last_q <= rd_last_d;
    end
    if (rd_valid_q) begin
      res_q.key_out <= 64'(rdata_q);
      res_q.source  <= 4'(rd_src_q);
      res_q.status  <= mrrg_pkg::ST_OK;
      res_q.last    <= rd_last_q;
    end else if (emit_v) begin
      res_q.key_out <= '0;
      res_q.source  <= emit_src;
      res_q.status  <= emit_st;
      res_q.last    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= cur_q.key[KEY_BITS-1:0];
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

  a_no_emit_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_v && rd_valid_q))
    else $error("direct result collides with store read result");

  a_scan_start_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (sp_q < act))
    else $error("scan started from an unreduced start pointer");

  a_scan_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q < grp))
    else $error("scan kept going after the group was complete");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (fill_rd != '0))
    else $error("group pop from an empty queue");

endmodule

// ----- sv/multi_stack_round_robin_gather.sv -----
// ----------------------------------------------------------------------------
// multi_stack_round_robin_gather
// Per-queue key stacks with push, pop and round-robin group gather.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  request   in         start / busy              req_i   (mode, queue, key)
//  result    out        res_strobe_o, one cycle   res_o   (key_out, source,
//                                                          status, last)
//  config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Push and refused pop: the request passes the front queue, the executor's
//  command register and the result register. Pop adds a key store read. Gather
//  reduces the start pointer (only if active_queues shrank), scans the fill
//  counts (one per cycle, up to active_queues) and reads the group (one store
//  read per cycle) before the last word; a failed gather answers after the scan.
//  Two requests queue ahead of the executor; busy is high when both are held.
//  Reset clears fill counts and start pointer and restores config defaults;
//  the key store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_stack_round_robin_gather #(
  parameter int MAX_QUEUES = 16,
  parameter int DEPTH      = 128,
  parameter int KEY_BITS   = 64,
  parameter int MAX_GROUP  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mrrg_pkg::req_t req_i,
  output mrrg_pkg::res_t res_o,
  output logic           res_strobe_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  mrrg_pkg::cfg_t cfg_q;
  mrrg_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_queues <= 5'd16;
      cfg_q.group_size    <= 4'd4;
      cfg_q.capacity      <= 8'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mrrg_pkg::CFG_ACTIVE:   cfg_q.active_queues <= cfg_data_i[4:0];
        mrrg_pkg::CFG_GROUP:    cfg_q.group_size    <= cfg_data_i[3:0];
        mrrg_pkg::CFG_CAPACITY: cfg_q.capacity      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrrg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  mrrg_back #(
    .MAX_QUEUES (MAX_QUEUES),
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .MAX_GROUP  (MAX_GROUP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

// ----- verif/multi_stack_round_robin_gather_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_stack_round_robin_gather_tb
// Drives push, pop and gather words into the block in random bursts. A local
// model of the per-queue stacks, fill levels and rotating gather start
// predicts every result word, and the monitor checks each one in order.
// Directed checks cover the special cases. Several random register settings
// follow, and one deep fill phase runs a queue to its full depth.
// ----------------------------------------------------------------------------
module multi_stack_round_robin_gather_tb;

  localparam int NQ          = 16;
  localparam int STACK_DEPTH = 128;
  localparam int GROUP_MAX   = 8;
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           start       = 1'b0;
  logic           busy;
  mrrg_pkg::req_t req_i       = '0;
  mrrg_pkg::res_t res_o;
  logic           res_strobe_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index_i = '0;
  logic [7:0]     cfg_data_i  = '0;

  multi_stack_round_robin_gather dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // model state
  logic [63:0] stack_mem [NQ][STACK_DEPTH];
  logic [7:0]  fill_level [NQ] = '{default: 8'd0};
  logic [3:0]  rr_start      = '0;
  logic [4:0]  model_active  = 5'd16;
  logic [3:0]  model_group   = 4'd4;
  logic [7:0]  model_cap     = 8'd100;

  mrrg_pkg::req_t req_backlog [$];
  mrrg_pkg::res_t due_results [$];
  mrrg_pkg::res_t want;
  int   n_errors   = 0;
  int   burst_left = 0;
  int   gap_left   = 0;

  function automatic int active_count();
    if (model_active < 1) return 1;
    if (model_active > NQ) return NQ;
    return model_active;
  endfunction

  function automatic void expect_word(input mrrg_pkg::res_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void model_request(input mrrg_pkg::req_t rq);
    int   act, grp, cap, first, idx, cnt;
    int   picks [GROUP_MAX];
    mrrg_pkg::res_t r;
    act = active_count();
    grp = (model_group < 1) ? 1 : (model_group > GROUP_MAX) ? GROUP_MAX : model_group;
    cap = (model_cap > STACK_DEPTH) ? STACK_DEPTH : model_cap;
    r = '0;
    r.source = rq.queue;
    r.last = 1'b1;
    case (rq.mode)
      mrrg_pkg::MODE_PUSH: begin
        if (rq.queue >= act || fill_level[rq.queue] >= cap) begin
          r.status = mrrg_pkg::ST_FULL;
        end else begin
          stack_mem[rq.queue][fill_level[rq.queue]] = rq.key;
          fill_level[rq.queue]++;
          r.status = mrrg_pkg::ST_OK;
        end
        expect_word(r);
      end
      mrrg_pkg::MODE_POP: begin
        if (rq.queue >= act || fill_level[rq.queue] == 0) begin
          r.status = mrrg_pkg::ST_EMPTY;
        end else begin
          fill_level[rq.queue]--;
          r.key_out = stack_mem[rq.queue][fill_level[rq.queue]];
          r.status = mrrg_pkg::ST_OK;
        end
        expect_word(r);
      end
      mrrg_pkg::MODE_GATHER: begin
        first = rr_start % act;
        cnt = 0;
        for (int i = 0; i < act && cnt < grp; i++) begin
          idx = (first + i) % act;
          if (fill_level[idx] != 0) begin
            picks[cnt] = idx;
            cnt++;
          end
        end
        rr_start = 4'((first + 1) % act);
        if (cnt < grp) begin
          r.source = 4'(first);
          r.status = mrrg_pkg::ST_NOT_READY;
          expect_word(r);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            idx = picks[i];
            fill_level[idx]--;
            r.key_out = stack_mem[idx][fill_level[idx]];
            r.source = 4'(idx);
            r.status = mrrg_pkg::ST_OK;
            r.last = (i == cnt - 1);
            expect_word(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // request driver: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) model_request(req_i);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req_i <= req_backlog.pop_front();
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 19);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected word key=%h src=%0d st=%0d last=%0b", $time,
                 res_o.key_out, res_o.source, res_o.status, res_o.last);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (res_o.key_out !== want.key_out || res_o.source !== want.source ||
            res_o.status !== want.status || res_o.last !== want.last) begin
          $display("%0t: mismatch exp key=%h src=%0d st=%0d last=%0b", $time,
                   want.key_out, want.source, want.status, want.last);
          $display("%0t:          got key=%h src=%0d st=%0d last=%0b", $time,
                   res_o.key_out, res_o.source, res_o.status, res_o.last);
          n_errors++;
        end
      end
    end
  end

  task automatic add_req(input logic [1:0] mode, input logic [3:0] q,
                         input logic [63:0] key);
    mrrg_pkg::req_t rq;
    rq.mode = mode;
    rq.queue = q;
    rq.key = key;
    req_backlog.insert(req_backlog.size(), rq);
  endtask

  // wait for the block to drain, then cover words that cause no result
  task automatic settle();
    while (req_backlog.size() != 0 || start || due_results.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mrrg_pkg::CFG_ACTIVE:   model_active = val[4:0];
      mrrg_pkg::CFG_GROUP:    model_group = val[3:0];
      mrrg_pkg::CFG_CAPACITY: model_cap = val;
      default: ;
    endcase
  endtask

  task automatic random_phase(input int n_items);
    int          n, pick, act;
    logic [1:0]  mode;
    logic [3:0]  q;
    logic [63:0] key;
    n = 0;
    act = active_count();
    while (n < n_items) begin
      pick = $urandom_range(0, 99);
      mode = (pick < 45) ? mrrg_pkg::MODE_PUSH : (pick < 62) ? mrrg_pkg::MODE_POP :
             (pick < 95) ? mrrg_pkg::MODE_GATHER : MODE_NONE;
      q = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, NQ - 1)) :
          4'($urandom_range(0, act - 1));
      case ($urandom_range(0, 15))
        0:       key = '1;
        1:       key = '0;
        default: key = {$urandom, $urandom};
      endcase
      add_req(mode, q, key);
      if (mode != MODE_NONE) n++;
    end
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int act_w, grp_hi;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 16 queues, group of 4, capacity 100
    add_req(mrrg_pkg::MODE_GATHER, 4'd0, 64'd0);
    add_req(mrrg_pkg::MODE_POP, 4'd0, 64'd0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd0, '1);
    add_req(mrrg_pkg::MODE_PUSH, 4'd15, 64'd0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd1, 64'h8000_0000_0000_0000);
    add_req(mrrg_pkg::MODE_PUSH, 4'd2, 64'd1);
    add_req(mrrg_pkg::MODE_POP, 4'd15, 64'd0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA);
    add_req(mrrg_pkg::MODE_PUSH, 4'd7, 64'h5555_5555_5555_5555);
    add_req(mrrg_pkg::MODE_GATHER, 4'd9, 64'd0);
    add_req(MODE_NONE, 4'd5, '1);
    add_req(mrrg_pkg::MODE_POP, 4'd0, 64'd0);
    add_req(mrrg_pkg::MODE_POP, 4'd0, 64'd0);
    settle();

    // three queues, group larger than active set, capacity 1
    write_reg(mrrg_pkg::CFG_ACTIVE, 8'd3);
    write_reg(mrrg_pkg::CFG_GROUP, 8'd8);
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd1);
    write_reg(CFG_UNUSED, 8'hFF);
    add_req(mrrg_pkg::MODE_PUSH, 4'd0, 64'h1234_5678_9ABC_DEF0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd0, 64'h0F0F_0F0F_0F0F_0F0F);
    add_req(mrrg_pkg::MODE_PUSH, 4'd5, 64'd3);
    add_req(mrrg_pkg::MODE_POP, 4'd5, 64'd0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd2, 64'hFEDC_BA98_7654_3210);
    add_req(mrrg_pkg::MODE_GATHER, 4'd0, 64'd0);
    settle();

    // group 0 clamps to 1, capacity 0 refuses every push
    write_reg(mrrg_pkg::CFG_GROUP, 8'd0);
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd0);
    add_req(mrrg_pkg::MODE_PUSH, 4'd1, 64'd7);
    add_req(mrrg_pkg::MODE_GATHER, 4'd0, 64'd0);
    add_req(mrrg_pkg::MODE_GATHER, 4'd0, 64'd0);
    settle();

    // active 0 clamps to 1, group 15 clamps to 8, capacity 255 clamps to depth
    write_reg(mrrg_pkg::CFG_ACTIVE, 8'd0);
    write_reg(mrrg_pkg::CFG_GROUP, 8'd15);
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd255);
    add_req(mrrg_pkg::MODE_PUSH, 4'd0, 64'd11);
    add_req(mrrg_pkg::MODE_PUSH, 4'd1, 64'd12);
    add_req(mrrg_pkg::MODE_GATHER, 4'd0, 64'd0);
    add_req(mrrg_pkg::MODE_POP, 4'd0, 64'd0);
    settle();

    // capacity lowered below a queue's fill: pushes refused, pops drain
    write_reg(mrrg_pkg::CFG_ACTIVE, 8'd31);
    write_reg(mrrg_pkg::CFG_GROUP, 8'd1);
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd6);
    for (int i = 0; i < 4; i++) add_req(mrrg_pkg::MODE_PUSH, 4'd4, {$urandom, $urandom});
    settle();
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd2);
    add_req(mrrg_pkg::MODE_PUSH, 4'd4, 64'd99);
    for (int i = 0; i < 5; i++) add_req(mrrg_pkg::MODE_POP, 4'd4, 64'd0);
    settle();

    // deep fill: one queue pushed past the full stack depth
    write_reg(mrrg_pkg::CFG_ACTIVE, 8'd2);
    write_reg(mrrg_pkg::CFG_GROUP, 8'd2);
    write_reg(mrrg_pkg::CFG_CAPACITY, 8'd200);
    for (int i = 0; i < STACK_DEPTH + 2; i++) begin
      add_req(mrrg_pkg::MODE_PUSH, 4'd0, {$urandom, $urandom});
    end
    settle();

    for (int p = 0; p < 6; p++) begin
      act_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      write_reg(mrrg_pkg::CFG_ACTIVE, act_w[7:0]);
      grp_hi = (active_count() > GROUP_MAX) ? GROUP_MAX : active_count();
      write_reg(mrrg_pkg::CFG_GROUP, ($urandom_range(0, 5) == 0) ?
                8'($urandom_range(0, 15)) : 8'($urandom_range(1, grp_hi)));
      write_reg(mrrg_pkg::CFG_CAPACITY, ($urandom_range(0, 3) == 0) ?
                8'($urandom_range(0, 255)) : 8'($urandom_range(1, 8)));
      random_phase(48);
      settle();
    end

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
